[design/bwba_pkg.sv]
// Shared types, widths and codes for the bit window byte access block.
package bwba_pkg;

  localparam int STORE_BYTES_DEF = 256;

  localparam int OP_W    = 2;
  localparam int DATA_W  = 8;
  localparam int MOVED_W = 4;
  localparam int LEFT_W  = 12;
  localparam int FIRST_W = 11;
  localparam int CFG_W   = 12;
  // Cursor never passes first_bit + window_bits, both bounded by their widths.
  localparam int CUR_W   = 13;
  localparam int IDX_W   = CUR_W - 3;
  localparam int GAP_W   = 3;
  localparam int QDEPTH  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RD_PART  = 2'd0,
    OP_RD_ALIGN = 2'd1,
    OP_WR_PART  = 2'd2,
    OP_WR_ALIGN = 2'd3
  } op_t;

  typedef enum logic {
    REG_FIRST_BIT   = 1'b0,
    REG_WINDOW_BITS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_st_t;

  // One classified operation, handed from the front to the back.
  typedef struct packed {
    logic               mem_en;
    logic               is_wr;
    logic [DATA_W-1:0]  mask;
    logic [GAP_W-1:0]   gap;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  wdata;
    logic [MOVED_W-1:0] moved;
    logic [LEFT_W-1:0]  left;
    logic [MOVED_W-1:0] nws;
    logic               err;
  } entry_t;

endpackage

[design/bwba_ifs.sv]
// Valid/ready channel interfaces for operations in and results out.
interface bwba_in_if;
  logic                        valid;
  logic                        ready;
  logic [bwba_pkg::OP_W-1:0]   opcode;
  logic [bwba_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output opcode, output write_data, input ready);
  modport sink (input valid, input opcode, input write_data, output ready);
endinterface

interface bwba_out_if;
  logic                         valid;
  logic                         ready;
  logic [bwba_pkg::DATA_W-1:0]  read_data;
  logic [bwba_pkg::MOVED_W-1:0] bits_moved;
  logic [bwba_pkg::LEFT_W-1:0]  bits_left;
  logic [bwba_pkg::MOVED_W-1:0] next_write_size;
  logic                         error;

  modport source (output valid, output read_data, output bits_moved, output bits_left,
                  output next_write_size, output error, input ready);
  modport sink (input valid, input read_data, input bits_moved, input bits_left,
                input next_write_size, input error, output ready);
endinterface

[design/bwba_front.sv]
// Front end: cursor and window registers, operation classification, config reload.
module bwba_front #(
  parameter int STORE_BYTES = bwba_pkg::STORE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bwba_in_if.sink                    in_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bwba_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       clearing,
  input  logic                       q_full,
  output logic                       q_push,
  output bwba_pkg::entry_t           q_entry
);

  localparam logic [31:0] TOTAL_U = 32'(STORE_BYTES * 8);
  localparam logic [31:0] STORE_U = 32'(STORE_BYTES);

  logic [bwba_pkg::CUR_W-1:0]   cursor_r, cursor_nxt;
  logic [bwba_pkg::LEFT_W-1:0]  remaining_r, remaining_nxt;
  logic [bwba_pkg::FIRST_W-1:0] first_r, first_nxt;
  logic [bwba_pkg::LEFT_W-1:0]  window_r, window_nxt;

  bwba_pkg::op_t                op;
  logic [2:0]                   s;
  logic [3:0]                   sz;
  logic [bwba_pkg::MOVED_W-1:0] moved;
  logic [bwba_pkg::GAP_W-1:0]   gap;
  logic [bwba_pkg::DATA_W-1:0]  mask;
  logic                         act;
  logic                         err;
  logic [bwba_pkg::IDX_W-1:0]   idx;
  logic                         in_range;
  logic [bwba_pkg::CUR_W-1:0]   cursor_adv;
  logic [bwba_pkg::LEFT_W-1:0]  remaining_adv;
  logic [bwba_pkg::LEFT_W-1:0]  reload_rem;
  logic [31:0]                  room;
  logic [bwba_pkg::CUR_W:0]     span;

  // Bits a partial write covers at a given cursor phase and length.
  function automatic logic [bwba_pkg::MOVED_W-1:0] psize(
    input logic [2:0]                  ph,
    input logic [bwba_pkg::LEFT_W-1:0] r
  );
    logic [3:0] lim;
    lim = (ph != 3'd0) ? (4'd8 - {1'b0, ph}) : 4'd8;
    if (r == '0) begin
      return '0;
    end else if (r < 12'(lim)) begin
      return r[3:0];
    end else begin
      return lim;
    end
  endfunction

  assign q_push      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !clearing && !q_full;

  // Classify the operation against the current cursor.
  always_comb begin
    op    = bwba_pkg::op_t'(in_ch.opcode);
    s     = cursor_r[2:0];
    sz    = 4'd8 - {1'b0, s};
    moved = '0;
    gap   = '0;
    mask  = '0;
    act   = 1'b0;
    err   = 1'b0;
    if (op inside {bwba_pkg::OP_RD_ALIGN, bwba_pkg::OP_WR_ALIGN}) begin
      if (remaining_r < 12'd8) begin
        err = 1'b1;
      end else begin
        moved = 4'd8;
        mask  = 8'hFF;
        act   = 1'b1;
      end
    end else if (remaining_r != '0 && (s != 3'd0 || remaining_r < 12'd8)) begin
      act = 1'b1;
      if (s != 3'd0) begin
        if (remaining_r < 12'(sz)) begin
          moved = remaining_r[3:0];
          gap   = 3'(sz - remaining_r[3:0]);
        end else begin
          moved = sz;
        end
      end else begin
        moved = remaining_r[3:0];
        gap   = 3'(4'd8 - remaining_r[3:0]);
      end
      mask = (8'hFF >> s) & (8'hFF << gap);
    end
  end

  assign idx           = cursor_r[bwba_pkg::CUR_W-1:3];
  assign in_range      = 32'(idx) < STORE_U;
  assign cursor_adv    = cursor_r + bwba_pkg::CUR_W'(moved);
  assign remaining_adv = remaining_r - bwba_pkg::LEFT_W'(moved);

  always_comb begin
    q_entry.mem_en = act && in_range;
    q_entry.is_wr  = (op == bwba_pkg::OP_WR_PART) || (op == bwba_pkg::OP_WR_ALIGN);
    q_entry.mask   = mask;
    q_entry.gap    = gap;
    q_entry.idx    = idx;
    q_entry.wdata  = in_ch.write_data;
    q_entry.moved  = moved;
    q_entry.left   = remaining_adv;
    q_entry.nws    = psize(cursor_adv[2:0], remaining_adv);
    q_entry.err    = err;
  end

  // Register writes and the window reload they trigger.
  always_comb begin
    first_nxt     = first_r;
    window_nxt    = window_r;
    cursor_nxt    = cursor_r;
    remaining_nxt = remaining_r;
    if (cfg_we) begin
      case (bwba_pkg::reg_idx_t'(cfg_index))
        bwba_pkg::REG_FIRST_BIT:   first_nxt  = cfg_wdata[bwba_pkg::FIRST_W-1:0];
        bwba_pkg::REG_WINDOW_BITS: window_nxt = cfg_wdata;
        default: ;
      endcase
    end
    room = TOTAL_U - 32'(first_nxt);
    if (32'(first_nxt) >= TOTAL_U) begin
      reload_rem = '0;
    end else if (32'(window_nxt) > room) begin
      reload_rem = room[bwba_pkg::LEFT_W-1:0];
    end else begin
      reload_rem = window_nxt;
    end
    if (cfg_we) begin
      cursor_nxt    = bwba_pkg::CUR_W'(first_nxt);
      remaining_nxt = reload_rem;
    end else if (q_push) begin
      cursor_nxt    = cursor_adv;
      remaining_nxt = remaining_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      remaining_r <= '0;
      first_r     <= '0;
      window_r    <= '0;
    end else begin
      cursor_r    <= cursor_nxt;
      remaining_r <= remaining_nxt;
      first_r     <= first_nxt;
      window_r    <= window_nxt;
    end
  end

  assign span = (bwba_pkg::CUR_W + 1)'(cursor_r) + (bwba_pkg::CUR_W + 1)'(remaining_r);

  a_span_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !cfg_we) |=> span == $past(span))
    else $error("cursor plus remaining length changed across a transfer");

  a_moved_fits: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> bwba_pkg::LEFT_W'(moved) <= remaining_r)
    else $error("operation moves more bits than remain");

endmodule

[design/bwba_queue.sv]
// Short queue of classified operations between front and back.
module bwba_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bwba_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output bwba_pkg::entry_t head
);

  localparam int PTR_W = (bwba_pkg::QDEPTH > 1) ? $clog2(bwba_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(bwba_pkg::QDEPTH + 1);

  bwba_pkg::entry_t   entries_r [bwba_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(bwba_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count_r == CNT_W'(bwba_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("back end popped an empty queue");

endmodule

[design/bwba_back.sv]
// Back end: byte store, clearing pass, read-modify-write and result register.
module bwba_back #(
  parameter int STORE_BYTES = bwba_pkg::STORE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  bwba_pkg::entry_t q_head,
  output logic             clearing,
  bwba_out_if.source       out_ch
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic [bwba_pkg::DATA_W-1:0]  store_r [STORE_BYTES];
  logic [bwba_pkg::DATA_W-1:0]  rdata_r;

  bwba_pkg::back_st_t           st_r, st_nxt;
  logic [AW-1:0]                clr_addr_r, clr_addr_nxt;
  bwba_pkg::entry_t             cur_r, cur_nxt;

  logic                         mem_we;
  logic                         mem_re;
  logic [AW-1:0]                mem_waddr;
  logic [AW-1:0]                mem_raddr;
  logic [bwba_pkg::DATA_W-1:0]  mem_wdata;
  logic [bwba_pkg::DATA_W-1:0]  merged;
  logic [bwba_pkg::DATA_W-1:0]  rd_val;
  logic                         out_load;

  logic                         out_valid_r;
  logic [bwba_pkg::DATA_W-1:0]  out_rd_r;
  logic [bwba_pkg::MOVED_W-1:0] out_moved_r;
  logic [bwba_pkg::LEFT_W-1:0]  out_left_r;
  logic [bwba_pkg::MOVED_W-1:0] out_nws_r;
  logic                         out_err_r;

  assign merged = (rdata_r & ~cur_r.mask) | (8'(cur_r.wdata << cur_r.gap) & cur_r.mask);
  assign rd_val = (cur_r.mem_en && !cur_r.is_wr)
                  ? 8'((rdata_r & cur_r.mask) >> cur_r.gap) : '0;

  assign mem_raddr = AW'(q_head.idx);
  assign clearing  = (st_r == bwba_pkg::BK_CLEAR);

  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    cur_nxt      = cur_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = clr_addr_r;
    mem_wdata    = '0;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    case (st_r)
      bwba_pkg::BK_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(STORE_BYTES - 1)) begin
          st_nxt = bwba_pkg::BK_IDLE;
        end
      end
      bwba_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          mem_re  = 1'b1;
          cur_nxt = q_head;
          st_nxt  = bwba_pkg::BK_EXEC;
        end
      end
      bwba_pkg::BK_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          mem_we    = cur_r.mem_en && cur_r.is_wr;
          mem_waddr = AW'(cur_r.idx);
          mem_wdata = merged;
          st_nxt    = bwba_pkg::BK_IDLE;
        end
      end
      default: st_nxt = bwba_pkg::BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= bwba_pkg::BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (out_load) begin
      out_rd_r    <= rd_val;
      out_moved_r <= cur_r.moved;
      out_left_r  <= cur_r.left;
      out_nws_r   <= cur_r.nws;
      out_err_r   <= cur_r.err;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= store_r[mem_raddr];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_rd_r;
  assign out_ch.bits_moved      = out_moved_r;
  assign out_ch.bits_left       = out_left_r;
  assign out_ch.next_write_size = out_nws_r;
  assign out_ch.error           = out_err_r;

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == bwba_pkg::BK_CLEAR) |-> (!out_valid_r && !q_pop))
    else $error("result or pop during the clearing pass");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == bwba_pkg::BK_EXEC && (!out_valid_r || out_ch.ready))
      |=> (out_valid_r && st_r == bwba_pkg::BK_IDLE))
    else $error("executed operation did not reach the result register");

  a_err_inert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_rd_r == '0 && out_moved_r == '0))
    else $error("flagged aligned access moved data");

endmodule

[design/bit_window_byte_access_top.sv]
// Top level of the bit window byte access block: front, queue and back wired together.
//
// A byte store of STORE_BYTES bytes read and written through a bit cursor that walks
// a window, most significant bit of each byte first. Operations arrive on in_ch
// (read partial, read aligned, write partial, write aligned); each produces exactly
// one result on out_ch carrying the right-aligned read bits, the bits moved, the bits
// left in the window and the size of the next partial write. The front classifies an
// operation and advances the cursor in the cycle it is accepted; the back performs the
// store access. In the back an operation first gets a registered read of the store,
// then merge, write-back and result load; the back takes no new operation until the
// last one is through, and a result waits in the result register while out_ch is
// stalled. A two-entry queue between front and back keeps accepting while a finished
// result waits on out_ch. After reset the store is cleared one byte per cycle,
// during which in_ch is held not ready; configuration
// writes are taken at any time. Writing either register (cfg_index 0: first_bit,
// 1: window_bits) reloads the cursor to first_bit and the window length clamped to the
// store end; write configuration only while no operation is in flight.
module bit_window_byte_access_top #(
  parameter int STORE_BYTES = bwba_pkg::STORE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bwba_in_if.sink                    in_ch,
  bwba_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bwba_pkg::CFG_W-1:0] cfg_wdata
);

  // Queue handshake between front and back.
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic             clearing;
  bwba_pkg::entry_t q_entry;
  bwba_pkg::entry_t q_head;

  // Accept, classify and advance the cursor.
  bwba_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // Hold classified operations until the back can take them.
  bwba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Clear the store, then read, merge, write back and drive results.
  bwba_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_head   (q_head),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

[tb/sv/bwba_access_checker.sv]
`timescale 1ns / 100ps
// Result checker for the bit window byte access block: predicts every result and compares it.
module bwba_access_checker #(
  parameter int STORE_BYTES = bwba_pkg::STORE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bwba_in_if                         in_ch,
  bwba_out_if                        out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bwba_pkg::CFG_W-1:0] cfg_wdata,
  output int                         pending,
  output int                         mismatches
);
  import bwba_pkg::*;

  localparam int unsigned TOTAL_BITS = STORE_BYTES * 8;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [MOVED_W-1:0] bits_moved;
    logic [LEFT_W-1:0]  bits_left;
    logic [MOVED_W-1:0] next_write_size;
    logic               error;
  } access_result_t;

  logic [DATA_W-1:0] store_copy [STORE_BYTES];
  int unsigned       cursor;
  int unsigned       window_left;
  int unsigned       first_reg;
  int unsigned       window_reg;
  access_result_t    expected_results [$];

  function automatic logic [DATA_W-1:0] byte_at(int unsigned bit_pos);
    return (bit_pos / 8 < STORE_BYTES) ? store_copy[bit_pos / 8] : '0;
  endfunction

  function automatic void put_byte(int unsigned bit_pos, logic [DATA_W-1:0] value);
    if (bit_pos / 8 < STORE_BYTES) store_copy[bit_pos / 8] = value;
  endfunction

  // Bits a partial write would cover at the current cursor.
  function automatic int unsigned next_partial();
    int unsigned sh;
    sh = cursor % 8;
    if (window_left == 0) return 0;
    if (sh > 0) return (window_left < 8 - sh) ? window_left : 8 - sh;
    return (window_left < 8) ? window_left : 8;
  endfunction

  function automatic void reload_window();
    cursor = first_reg;
    if (first_reg >= TOTAL_BITS) window_left = 0;
    else if (window_reg > TOTAL_BITS - first_reg) window_left = TOTAL_BITS - first_reg;
    else window_left = window_reg;
  endfunction

  function automatic access_result_t predict_access(op_t op, logic [DATA_W-1:0] wdata);
    int unsigned       sh;
    int unsigned       gap;
    int unsigned       moved;
    logic [DATA_W-1:0] cur_byte;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] rdata;
    logic              short_err;
    access_result_t    res;
    sh = cursor % 8;
    gap = 0;
    moved = 0;
    rdata = '0;
    short_err = 1'b0;
    if (op == OP_RD_ALIGN || op == OP_WR_ALIGN) begin
      // Whole byte holding the cursor, aligned or not; refuse when short of a byte.
      if (window_left < 8) begin
        short_err = 1'b1;
      end else begin
        if (op == OP_RD_ALIGN) rdata = byte_at(cursor);
        else put_byte(cursor, wdata);
        moved = 8;
      end
    end else if (window_left > 0 && (sh > 0 || window_left < 8)) begin
      cur_byte = byte_at(cursor);
      if (sh > 0) begin
        if (window_left < 8 - sh) begin
          moved = window_left;
          gap = 8 - sh - window_left;
        end else begin
          moved = 8 - sh;
        end
      end else begin
        moved = window_left;
        gap = 8 - window_left;
      end
      mask = (8'hFF >> sh) & (8'hFF << gap);
      if (op == OP_RD_PART) rdata = (cur_byte & mask) >> gap;
      else put_byte(cursor, (cur_byte & ~mask) | ((wdata << gap) & mask));
    end
    cursor += moved;
    window_left -= moved;
    res.read_data = rdata;
    res.bits_moved = MOVED_W'(moved);
    res.bits_left = LEFT_W'(window_left);
    res.next_write_size = MOVED_W'(next_partial());
    res.error = short_err;
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t seen;
    access_result_t want;
    if (!rst_n) begin
      foreach (store_copy[i]) store_copy[i] = '0;
      first_reg = 0;
      window_reg = 0;
      reload_window();
      expected_results.delete();
    end else begin
      // Retire first: a result never leaves in the cycle its operation enters.
      if (out_ch.valid && out_ch.ready) begin
        seen.read_data = out_ch.read_data;
        seen.bits_moved = out_ch.bits_moved;
        seen.bits_left = out_ch.bits_left;
        seen.next_write_size = out_ch.next_write_size;
        seen.error = out_ch.error;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result with none expected: rd=%h moved=%0d left=%0d nws=%0d err=%b",
                     $time, seen.read_data, seen.bits_moved, seen.bits_left,
                     seen.next_write_size, seen.error);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: mismatch exp rd=%h moved=%0d left=%0d nws=%0d err=%b",
                       $time, want.read_data, want.bits_moved, want.bits_left,
                       want.next_write_size, want.error);
              $display("%0t:          got rd=%h moved=%0d left=%0d nws=%0d err=%b",
                       $time, seen.read_data, seen.bits_moved, seen.bits_left,
                       seen.next_write_size, seen.error);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_FIRST_BIT) first_reg = cfg_wdata & 12'h7FF;
        else window_reg = cfg_wdata;
        reload_window();
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_access(op_t'(in_ch.opcode), in_ch.write_data));
    end
    pending = expected_results.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the bit window byte access block: stimulus, pacing and final verdict.
module tb;
  import bwba_pkg::*;

  localparam int ITEMS        = 1100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 8;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  reg_idx_t          cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  int                pending;
  int                mismatches;
  int                items_sent = 0;
  int                results_taken = 0;
  int                cycle_count = 0;
  bit                calm = 1'b0;

  bwba_in_if  in_ch ();
  bwba_out_if out_ch ();

  bit_window_byte_access_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bwba_access_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: fails the run once cycle_count reaches CYCLE_LIMIT, a bound that allows
  // for the store clear after reset and the long receiver holds.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: draw a stall before each transfer, drop ready for it, then
  // hold ready until a transfer happens. Twice in the run, hold off for a
  // long stretch so the back end and the queue fill and in_ch stalls while
  // the sender keeps offering.
  initial begin
    int wait_cycles;
    forever begin
      wait_cycles = calm ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      results_taken++;
      if (results_taken == 300 || results_taken == 800) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Offer one operation after a random gap; keep valid high across
  // back-to-back transfers so it is never lowered and raised in one step.
  task automatic offer(input op_t op, input logic [DATA_W-1:0] data);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.write_data <= data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back, after first
  // letting the checker record the last transfer.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Program one or both window registers, back to back, while idle.
  task automatic load_regs(input bit set_first, input bit set_window, input bit window_leads,
                           input logic [CFG_W-1:0] first_val,
                           input logic [CFG_W-1:0] window_val);
    reg_idx_t         idx [2];
    logic [CFG_W-1:0] val [2];
    int               n;
    n = 0;
    if (set_window && window_leads) begin
      idx[n] = REG_WINDOW_BITS;
      val[n] = window_val;
      n++;
    end
    if (set_first) begin
      idx[n] = REG_FIRST_BIT;
      val[n] = first_val;
      n++;
    end
    if (set_window && !window_leads) begin
      idx[n] = REG_WINDOW_BITS;
      val[n] = window_val;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic window(input logic [CFG_W-1:0] first_val, input logic [CFG_W-1:0] window_val);
    settle();
    load_regs(1'b1, 1'b1, 1'b0, first_val, window_val);
  endtask

  initial begin
    int               target;
    int               n;
    int               pick;
    logic [CFG_W-1:0] first_val;
    logic [CFG_W-1:0] window_val;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FIRST_BIT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_RD_PART;
    in_ch.write_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty window after reset: partials move nothing, aligned ops flag short.
    offer(OP_RD_PART, 8'h00);
    offer(OP_WR_PART, 8'hFF);
    offer(OP_RD_ALIGN, 8'h00);
    offer(OP_WR_ALIGN, 8'hFF);

    // Full store window: aligned writes, then partials in the aligned middle.
    window(12'd0, 12'd2048);
    offer(OP_WR_ALIGN, 8'hFF);
    offer(OP_WR_ALIGN, 8'h00);
    offer(OP_RD_PART, 8'h00);
    offer(OP_WR_PART, 8'hFF);
    window(12'd0, 12'd2048);
    offer(OP_RD_ALIGN, 8'h00);
    offer(OP_RD_ALIGN, 8'h00);

    // Unaligned start: trailing bits, then a short tail, then an aligned op short of a byte.
    window(12'd3, 12'd10);
    offer(OP_RD_PART, 8'h00);
    offer(OP_RD_PART, 8'h00);
    offer(OP_WR_ALIGN, 8'hA5);

    // Last bits of the store with an oversized window clamped to the end.
    window(12'd2045, 12'd4095);
    offer(OP_WR_PART, 8'h05);
    offer(OP_RD_ALIGN, 8'h00);
    window(12'd2045, 12'd4095);
    offer(OP_RD_PART, 8'h00);

    // One bit inside a byte, with bits on both sides untouched.
    window(12'd5, 12'd1);
    offer(OP_WR_PART, 8'hFE);

    // Aligned access at an unaligned cursor uses the whole byte.
    window(12'd1, 12'd20);
    offer(OP_RD_ALIGN, 8'h00);
    offer(OP_WR_ALIGN, 8'h5A);

    // Random phases: reprogram while idle, then a burst of random operations.
    // Most windows are short and start near the bottom so bytes are reused
    // and the window end is reached often.
    target = items_sent + ITEMS;
    while (items_sent < target) begin
      settle();
      pick = $urandom_range(0, 15);
      if (pick == 0) first_val = '0;
      else if (pick == 1) first_val = 12'd2047;
      else if (pick == 2) first_val = CFG_W'($urandom_range(0, 2047));
      else first_val = CFG_W'($urandom_range(0, 127));
      // Bit 11 is not part of the start register; toggle it now and then.
      first_val[11] = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 15);
      if (pick == 0) window_val = '0;
      else if (pick == 1) window_val = 12'd2048;
      else if (pick == 2) window_val = 12'd4095;
      else if (pick == 3) window_val = CFG_W'($urandom_range(0, 4095));
      else window_val = CFG_W'($urandom_range(1, 80));
      pick = $urandom_range(0, 3);
      load_regs(pick != 1, pick != 0, 1'($urandom_range(0, 1)), first_val, window_val);
      calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(4, 40);
      repeat (n) offer(op_t'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)));
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
